// ===== rtl/b64c_pkg.sv =====
// b64c_pkg: shared types, constants and character mapping functions
// for the Base64 stream codec. No dependencies.
package b64c_pkg;

   localparam int unsigned SymW   = 8;
   localparam int unsigned SextW  = 6;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   // phase codes: position inside a 3-byte / 4-character group
   localparam logic [1:0] PH_0 = 2'd0;
   localparam logic [1:0] PH_1 = 2'd1;
   localparam logic [1:0] PH_2 = 2'd2;
   localparam logic [1:0] PH_3 = 2'd3;

   typedef struct packed {
      logic [SymW-1:0] sym;
      logic            last;
   } res_type;

   // 6-bit value to alphabet character
   function automatic logic [SymW-1:0] enc_char(input logic [SextW-1:0] v);
      logic [SymW-1:0] r;
      case (v) inside
         [6'd0:6'd25]:  r = 8'h41 + {2'b00, v};
         [6'd26:6'd51]: r = 8'h61 + {2'b00, v} - 8'd26;
         [6'd52:6'd61]: r = 8'h30 + {2'b00, v} - 8'd52;
         6'd62:         r = 8'h2B;
         default:       r = 8'h2F;
      endcase
      return r;
   endfunction

   // character to 6-bit value; anything outside the alphabet maps to 0
   function automatic logic [SextW-1:0] dec_value(input logic [SymW-1:0] c);
      logic [SymW-1:0] r;
      case (c) inside
         [8'h41:8'h5A]: r = c - 8'h41;
         [8'h61:8'h7A]: r = c - 8'h61 + 8'd26;
         [8'h30:8'h39]: r = c - 8'h30 + 8'd52;
         8'h2B:         r = 8'd62;
         8'h2F:         r = 8'd63;
         default:       r = 8'd0;
      endcase
      return r[SextW-1:0];
   endfunction

endpackage

// ===== rtl/base64_stream_codec.sv =====
// base64_stream_codec: streaming Base64 encoder/decoder (unpadded), direction
// set by the mode register. Depends on b64c_pkg.
//
//   channel | dir | handshake           | payload
//   req     | in  | req_valid/req_ready | req_in_symbol, req_in_last
//   rsp     | out | rsp_valid/rsp_ready | rsp_out_symbol, rsp_out_last, rsp_out_end
//   csr     | in  | csr_valid/csr_ready | csr_mode
//
// A beat is mapped in the cycle it is accepted and its zero, one or two results
// land in a two-entry result register; the first shows on rsp the next cycle.
// The single result port limits the flow: after a beat that gives two results,
// the next is held off until the first has left. req_ready is high while the
// result register is empty or its last entry leaves this cycle. Synchronous
// reset clears mode, phase, carry bits and the result count. csr is always ready.
module base64_stream_codec (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_symbol,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_symbol,
   output logic       rsp_out_last,
   output logic       rsp_out_end,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_mode
);

   logic                      mode_ff, mode_in;
   logic [1:0]                phase_ff, phase_in;
   logic [b64c_pkg::SextW-1:0] carry_ff, carry_in;
   logic [1:0]                cnt_ff, cnt_in;
   b64c_pkg::res_type         hd_ff, hd_in, tl_ff, tl_in;
   logic                      end_ff, end_in;

   logic                      req_fire, rsp_fire;
   logic [1:0]                n_res;
   logic [1:0]                nx_phase;
   logic [b64c_pkg::SextW-1:0] nx_carry, dv;
   logic [7:0]                s, sym0, sym1;

   assign csr_ready = 1'b1;
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign req_ready = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_ready);
   assign req_fire  = req_valid && req_ready;

   assign rsp_out_symbol = hd_ff.sym;
   assign rsp_out_last   = hd_ff.last;
   assign rsp_out_end    = end_ff;

   assign s  = req_in_symbol;
   assign dv = b64c_pkg::dec_value(s);

   // symbol mapping for the beat on req
   always_comb begin
      sym0     = '0;
      sym1     = '0;
      n_res    = 2'd0;
      nx_phase = phase_ff;
      nx_carry = carry_ff;
      if (mode_ff == b64c_pkg::MODE_ENCODE) begin
         case (phase_ff)
            b64c_pkg::PH_0: begin
               sym0     = b64c_pkg::enc_char(s[7:2]);
               sym1     = b64c_pkg::enc_char({s[1:0], 4'b0000});
               nx_carry = {4'b0000, s[1:0]};
               nx_phase = b64c_pkg::PH_1;
               n_res    = req_in_last ? 2'd2 : 2'd1;
            end
            b64c_pkg::PH_1: begin
               sym0     = b64c_pkg::enc_char({carry_ff[1:0], s[7:4]});
               sym1     = b64c_pkg::enc_char({s[3:0], 2'b00});
               nx_carry = {2'b00, s[3:0]};
               nx_phase = b64c_pkg::PH_2;
               n_res    = req_in_last ? 2'd2 : 2'd1;
            end
            default: begin
               sym0     = b64c_pkg::enc_char({carry_ff[3:0], s[7:6]});
               sym1     = b64c_pkg::enc_char(s[5:0]);
               nx_carry = '0;
               nx_phase = b64c_pkg::PH_0;
               n_res    = 2'd2;
            end
         endcase
      end else begin
         case (phase_ff)
            b64c_pkg::PH_0: begin
               nx_carry = dv;
               nx_phase = b64c_pkg::PH_1;
            end
            b64c_pkg::PH_1: begin
               sym0     = {carry_ff[5:0], dv[5:4]};
               nx_carry = {2'b00, dv[3:0]};
               nx_phase = b64c_pkg::PH_2;
               n_res    = 2'd1;
            end
            b64c_pkg::PH_2: begin
               sym0     = {carry_ff[3:0], dv[5:2]};
               nx_carry = {4'b0000, dv[1:0]};
               nx_phase = b64c_pkg::PH_3;
               n_res    = 2'd1;
            end
            default: begin
               sym0     = {carry_ff[1:0], dv};
               nx_carry = '0;
               nx_phase = b64c_pkg::PH_0;
               n_res    = 2'd1;
            end
         endcase
      end
      if (req_in_last) begin
         nx_phase = b64c_pkg::PH_0;
         nx_carry = '0;
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      phase_in = phase_ff;
      carry_in = carry_ff;
      cnt_in   = cnt_ff;
      hd_in    = hd_ff;
      tl_in    = tl_ff;
      end_in   = end_ff;
      if (rsp_fire) begin
         cnt_in = cnt_ff - 2'd1;
         hd_in  = tl_ff;
      end
      if (csr_valid) begin
         mode_in  = csr_mode;
         phase_in = b64c_pkg::PH_0;
         carry_in = '0;
      end else if (req_fire) begin
         phase_in  = nx_phase;
         carry_in  = nx_carry;
         cnt_in    = n_res;
         hd_in.sym  = sym0;
         hd_in.last = (n_res == 2'd1);
         tl_in.sym  = sym1;
         tl_in.last = 1'b1;
         end_in     = req_in_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= b64c_pkg::MODE_ENCODE;
         phase_ff <= b64c_pkg::PH_0;
         carry_ff <= '0;
         cnt_ff   <= 2'd0;
      end else begin
         mode_ff  <= mode_in;
         phase_ff <= phase_in;
         carry_ff <= carry_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      hd_ff  <= hd_in;
      tl_ff  <= tl_in;
      end_ff <= end_in;
   end

   // result count never exceeds two entries
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result count out of range");

   // encoder never reaches the fourth phase
   a_enc_phase: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == b64c_pkg::MODE_ENCODE) |-> (phase_ff != b64c_pkg::PH_3))
      else $error("encoder phase out of range");

   // a pending second result is always the beat's final one
   a_tail_last: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> (tl_ff.last && !hd_ff.last))
      else $error("result last flags inconsistent");

   // a message end leaves no leftover state
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_in_last) |=> (phase_ff == b64c_pkg::PH_0 && carry_ff == '0))
      else $error("state not cleared after last beat");

   // decoded beats never give two results
   a_dec_single: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !csr_valid && mode_ff == b64c_pkg::MODE_DECODE) |=> (cnt_ff != 2'd2))
      else $error("decoder produced two results");

endmodule

// ===== tb/sv/b64_stream_monitor.sv =====
// b64_stream_monitor: watches the req, rsp and csr channels of the Base64 stream
// codec, predicts every rsp beat and compares it. Depends on b64c_pkg.
`timescale 1ns / 100ps

module b64_stream_monitor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_in_symbol,
   input  logic       req_in_last,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_out_symbol,
   input  logic       rsp_out_last,
   input  logic       rsp_out_end,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic       csr_mode,
   output int         error_count,
   output int         pending
);

   localparam logic [511:0] B64_CHARS =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct packed {
      logic [7:0] symbol;
      logic       beat_last;
      logic       msg_end;
   } codec_beat_type;

   codec_beat_type expected_syms[$];
   codec_beat_type want;

   logic       cur_mode;
   logic [1:0] cur_phase;
   logic [5:0] carry;

   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      return B64_CHARS[8*(63 - int'(v)) +: 8];
   endfunction

   // characters outside the alphabet, '=' among them, count as zero
   function automatic logic [5:0] char_sextet(input logic [7:0] c);
      for (int i = 0; i < 64; i++)
         if (B64_CHARS[8*(63 - i) +: 8] == c)
            return 6'(i);
      return 6'd0;
   endfunction

   task automatic predict_codec_beat(input logic [7:0] sym, input logic last);
      logic [7:0] outs[2];
      logic [5:0] v;
      int         n;
      n = 0;
      if (cur_mode == b64c_pkg::MODE_ENCODE) begin
         case (cur_phase)
            b64c_pkg::PH_0: begin
               outs[0] = sextet_char(sym[7:2]);
               carry = {4'b0, sym[1:0]};
               cur_phase = b64c_pkg::PH_1;
               n = 1;
            end
            b64c_pkg::PH_1: begin
               outs[0] = sextet_char({carry[1:0], sym[7:4]});
               carry = {2'b0, sym[3:0]};
               cur_phase = b64c_pkg::PH_2;
               n = 1;
            end
            default: begin
               outs[0] = sextet_char({carry[3:0], sym[7:6]});
               outs[1] = sextet_char(sym[5:0]);
               carry = '0;
               cur_phase = b64c_pkg::PH_0;
               n = 2;
            end
         endcase
         // flush leftover bits, left-aligned, no padding
         if (last) begin
            if (cur_phase == b64c_pkg::PH_1) begin
               outs[n] = sextet_char({carry[1:0], 4'b0});
               n = n + 1;
            end else if (cur_phase == b64c_pkg::PH_2) begin
               outs[n] = sextet_char({carry[3:0], 2'b0});
               n = n + 1;
            end
         end
      end else begin
         v = char_sextet(sym);
         case (cur_phase)
            b64c_pkg::PH_0: begin
               carry = v;
               cur_phase = b64c_pkg::PH_1;
            end
            b64c_pkg::PH_1: begin
               outs[0] = {carry[5:0], v[5:4]};
               carry = {2'b0, v[3:0]};
               cur_phase = b64c_pkg::PH_2;
               n = 1;
            end
            b64c_pkg::PH_2: begin
               outs[0] = {carry[3:0], v[5:2]};
               carry = {4'b0, v[1:0]};
               cur_phase = b64c_pkg::PH_3;
               n = 1;
            end
            default: begin
               outs[0] = {carry[1:0], v};
               carry = '0;
               cur_phase = b64c_pkg::PH_0;
               n = 1;
            end
         endcase
      end
      if (last) begin
         cur_phase = b64c_pkg::PH_0;
         carry = '0;
      end
      for (int k = 0; k < n; k++)
         expected_syms.push_back('{symbol: outs[k], beat_last: (k == n - 1),
                                   msg_end: last});
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cur_mode = b64c_pkg::MODE_ENCODE;
         cur_phase = b64c_pkg::PH_0;
         carry = '0;
         expected_syms.delete();
         error_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            cur_mode = csr_mode;
            cur_phase = b64c_pkg::PH_0;
            carry = '0;
         end
         // a rsp beat never stems from the req beat taken at the same edge
         if (rsp_valid && rsp_ready) begin
            if (expected_syms.size() == 0) begin
               if (error_count < 10)
                  $display("unexpected rsp beat: sym %h last %b end %b",
                           rsp_out_symbol, rsp_out_last, rsp_out_end);
               error_count <= error_count + 1;
            end else begin
               want = expected_syms.pop_front();
               if (want.symbol !== rsp_out_symbol || want.beat_last !== rsp_out_last ||
                   want.msg_end !== rsp_out_end) begin
                  if (error_count < 10)
                     $display("rsp mismatch: exp sym %h last %b end %b, got %h %b %b",
                              want.symbol, want.beat_last, want.msg_end,
                              rsp_out_symbol, rsp_out_last, rsp_out_end);
                  error_count <= error_count + 1;
               end
            end
         end
         if (req_valid && req_ready)
            predict_codec_beat(req_in_symbol, req_in_last);
      end
      pending <= expected_syms.size();
   end

endmodule

// ===== tb/sv/base64_stream_codec_tb.sv =====
// base64_stream_codec_tb: drives directed and random messages in both codec modes
// with bursty input and stalling output. Depends on b64c_pkg, base64_stream_codec
// and b64_stream_monitor.
`timescale 1ns / 100ps

module base64_stream_codec_tb;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int ITEMS_PER_PHASE = 230;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_in_symbol;
   logic       req_in_last;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_symbol;
   logic       rsp_out_last;
   logic       rsp_out_end;
   logic       csr_valid;
   logic       csr_ready;
   logic       csr_mode;

   int         error_count;
   int         pending;
   int         cycles = 0;
   int         burst_left = 0;
   logic [9:0] stall_cycle = '0;

   base64_stream_codec dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_symbol  (req_in_symbol),
      .req_in_last    (req_in_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_symbol (rsp_out_symbol),
      .rsp_out_last   (rsp_out_last),
      .rsp_out_end    (rsp_out_end),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_mode       (csr_mode)
   );

   b64_stream_monitor monitor (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_symbol  (req_in_symbol),
      .req_in_last    (req_in_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_symbol (rsp_out_symbol),
      .rsp_out_last   (rsp_out_last),
      .rsp_out_end    (rsp_out_end),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_mode       (csr_mode),
      .error_count    (error_count),
      .pending        (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver: always ready, coin flip, rare stalls, then a fixed 1-in-8 stall
   always @(posedge clock) begin
      stall_cycle <= stall_cycle + 10'd1;
      case (stall_cycle[9:8])
         2'd0:    rsp_ready <= 1'b1;
         2'd1:    rsp_ready <= ($urandom_range(0, 1) == 1);
         2'd2:    rsp_ready <= ($urandom_range(0, 9) != 0);
         default: rsp_ready <= (stall_cycle[2:0] != 3'd7);
      endcase
   end

   // sender works in bursts; between two bursts valid may drop for a random gap
   task automatic send_beat(input logic [7:0] sym, input logic last);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0)
            gap = 0;
         else if ($urandom_range(0, 7) == 0)
            gap = $urandom_range(8, 20);
         else
            gap = $urandom_range(1, 4);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
      end
      burst_left = burst_left - 1;
      req_valid <= 1'b1;
      req_in_symbol <= sym;
      req_in_last <= last;
      do @(posedge clock); while (!req_ready);
   endtask

   // wait until every predicted rsp beat is out, then idle to let a silent beat settle
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      csr_valid <= 1'b1;
      csr_mode <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] random_symbol(input logic m);
      int k;
      if (m == b64c_pkg::MODE_ENCODE) begin
         case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
         endcase
      end
      case ($urandom_range(0, 19))
         0:       return "=";
         1:       return 8'($urandom_range(0, 255));
         2:       return 8'hFF;
         default: begin
            k = $urandom_range(0, 63);
            if (k < 26)      return 8'("A" + k);
            else if (k < 52) return 8'("a" + k - 26);
            else if (k < 62) return 8'("0" + k - 52);
            else if (k == 62) return "+";
            else             return "/";
         end
      endcase
   endfunction

   initial begin
      int   items_left;
      int   msg_len;
      logic phase_mode;
      req_valid <= 1'b0;
      req_in_symbol <= 8'h00;
      req_in_last <= 1'b0;
      csr_valid <= 1'b0;
      csr_mode <= b64c_pkg::MODE_ENCODE;
      reset <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // encode: messages ending after one, two, three and four bytes
      write_mode(b64c_pkg::MODE_ENCODE);
      send_beat(8'hFF, 1'b1);
      send_beat(8'h00, 1'b0);
      send_beat(8'hFF, 1'b1);
      send_beat(8'hFF, 1'b0);
      send_beat(8'h00, 1'b0);
      send_beat(8'hFF, 1'b1);
      send_beat(8'h4D, 1'b0);
      send_beat(8'h61, 1'b0);
      send_beat(8'h6E, 1'b0);
      send_beat(8'h00, 1'b1);
      drain_results();

      // decode: full group, lone last char giving nothing, unknown chars
      write_mode(b64c_pkg::MODE_DECODE);
      send_beat("T", 1'b0);
      send_beat("W", 1'b0);
      send_beat("F", 1'b0);
      send_beat("u", 1'b1);
      send_beat("=", 1'b1);
      send_beat("/", 1'b0);
      send_beat("/", 1'b1);
      send_beat(8'h00, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_beat("=", 1'b0);
      send_beat("9", 1'b1);
      // unfinished group, then a mode write must clear it
      send_beat("+", 1'b0);
      drain_results();

      for (int ph = 0; ph < 8; ph++) begin
         drain_results();
         phase_mode = (ph < 4) ? logic'(ph % 2) : logic'($urandom_range(0, 1));
         write_mode(phase_mode);
         items_left = ITEMS_PER_PHASE;
         while (items_left > 0) begin
            msg_len = $urandom_range(1, 12);
            // a message cut at the phase end is left open for the mode write
            for (int i = 0; i < msg_len && items_left > 0; i++) begin
               send_beat(random_symbol(phase_mode), (i == msg_len - 1));
               items_left = items_left - 1;
               if (items_left == ITEMS_PER_PHASE / 2)
                  drain_results();
            end
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
      if (error_count == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
